[sv/multi_channel_ring_pointer_manager_unit_defines.svh]
// Assertion macros for the multi-channel ring pointer manager.
// Used by the checker; expects clk and arst_n in scope.
`ifndef MULTI_CHANNEL_RING_POINTER_MANAGER_UNIT_DEFINES_SVH
`define MULTI_CHANNEL_RING_POINTER_MANAGER_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define MCRPM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define MCRPM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/mcrpm_pkg.sv]
// Package for the multi-channel ring pointer manager.
// Sizes, operation codes, register map and the per-channel entry type.
`default_nettype none

package mcrpm_pkg;

	localparam int CHANNELS   = 8;
	localparam int RING_DEPTH = 1024;

	localparam int CH_W  = 3;
	localparam int PTR_W = 10;
	localparam int CNT_W = 11;
	localparam int AMT_W = 11;

	localparam int APB_AW = 3;
	localparam int APB_DW = 32;

	localparam logic [1:0] KIND_RSV_RD = 2'd0;
	localparam logic [1:0] KIND_CMT_RD = 2'd1;
	localparam logic [1:0] KIND_RSV_WR = 2'd2;
	localparam logic [1:0] KIND_CMT_WR = 2'd3;

	localparam logic REG_RING_SIZE = 1'b0;

	localparam logic [CNT_W-1:0] RING_SIZE_RST = CNT_W'(RING_DEPTH);

	typedef struct packed {
		logic [PTR_W-1:0] rp;
		logic [PTR_W-1:0] wp;
		logic [CNT_W-1:0] fill;
	} ch_entry_t;

endpackage

`default_nettype wire

[sv/multi_channel_ring_pointer_manager_unit.sv]
// Multi-channel ring pointer manager: per-channel pointer memory and update logic.
// Depends on mcrpm_pkg.
//
//  port group | valid / stall        | payload
//  -----------+----------------------+--------------------------
//  request    | req_valid / req_stall| kind, channel, amount
//  response   | rsp_valid / rsp_stall| offset, granted, clamped
//  config     | APB psel/penable     | paddr, pwdata, prdata
//
// One item at a time in stage 1: the channel entry is read from a synchronous
// memory in the accept cycle; a commit writes it back as its result is registered.
// Reset: ring_size returns to 1024 and all channel entry valid bits clear;
// an entry that is not valid reads as zero. A ring_size write clears them too.
// A result waits in the output register while the next item is accepted;
// the pending item holds in stage 1 until the output register frees up.
`default_nettype none

module multi_channel_ring_pointer_manager_unit
	import mcrpm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [CH_W-1:0]   channel,
	input  wire logic [AMT_W-1:0]  amount,

	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic [PTR_W-1:0]       offset,
	output logic [CNT_W-1:0]       granted,
	output logic                   clamped,

	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	ch_entry_t          mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	logic [CNT_W-1:0]   ring_size_q;

	logic               busy_q;
	logic [1:0]         kind_s1;
	logic               chan_ok_s1;
	logic [CH_W-1:0]    chan_s1;
	logic [AMT_W-1:0]   amount_s1;
	ch_entry_t          rd_entry_s1;
	logic               rd_vld_s1;

	logic               rsp_valid_q;
	logic [PTR_W-1:0]   offset_q;
	logic [CNT_W-1:0]   granted_q;
	logic               clamped_q;

	logic               req_fire;
	logic               done;
	logic               cfg_wr;
	logic               chan_ok;

	logic [CNT_W-1:0]   eff;
	ch_entry_t          cur;
	ch_entry_t          upd;
	logic               is_wr;
	logic               is_cmt;
	logic [PTR_W-1:0]   pos;
	logic [CNT_W-1:0]   free_c;
	logic [CNT_W-1:0]   avail;
	logic [CNT_W-1:0]   room;
	logic [CNT_W-1:0]   lim;
	logic               over;
	logic [CNT_W-1:0]   nxt_sum;
	logic [PTR_W-1:0]   nxt_pos;
	logic [PTR_W-1:0]   res_offset;
	logic [CNT_W-1:0]   res_granted;
	logic               res_clamped;

	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite & pready & (paddr[2] == REG_RING_SIZE);
	assign prdata    = (paddr[2] == REG_RING_SIZE) ? APB_DW'(ring_size_q) : '0;

	assign req_stall = busy_q;
	assign req_fire  = req_valid & ~busy_q;
	assign done      = busy_q & (~rsp_valid_q | ~rsp_stall);
	assign chan_ok   = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));

	assign rsp_valid = rsp_valid_q;
	assign offset    = offset_q;
	assign granted   = granted_q;
	assign clamped   = clamped_q;

	always_comb begin
		if (ring_size_q == '0) begin
			eff = CNT_W'(1);
		end else if (ring_size_q > RING_SIZE_RST) begin
			eff = RING_SIZE_RST;
		end else begin
			eff = ring_size_q;
		end
	end

	always_comb begin
		cur    = rd_vld_s1 ? rd_entry_s1 : '0;
		is_wr  = (kind_s1 == KIND_RSV_WR) || (kind_s1 == KIND_CMT_WR);
		is_cmt = (kind_s1 == KIND_CMT_RD) || (kind_s1 == KIND_CMT_WR);
		pos    = is_wr ? cur.wp : cur.rp;
		free_c = eff - cur.fill;
		avail  = is_wr ? free_c : cur.fill;
		room   = eff - {1'b0, pos};
		over   = amount_s1 > avail;
		lim    = over ? avail : amount_s1;
		nxt_sum = {1'b0, pos} + lim;
		if (nxt_sum >= eff) begin
			nxt_pos = PTR_W'(nxt_sum - eff);
		end else begin
			nxt_pos = nxt_sum[PTR_W-1:0];
		end
		upd = cur;
		if (is_wr) begin
			upd.wp   = nxt_pos;
			upd.fill = cur.fill + lim;
		end else begin
			upd.rp   = nxt_pos;
			upd.fill = cur.fill - lim;
		end
		res_offset  = '0;
		res_granted = '0;
		res_clamped = 1'b0;
		if (chan_ok_s1) begin
			res_offset = pos;
			if (is_cmt) begin
				res_granted = lim;
				res_clamped = over;
			end else begin
				res_granted = (lim < room) ? lim : room;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			rd_entry_s1 <= mem[channel];
		end
		if (done && chan_ok_s1 && is_cmt) begin
			mem[chan_s1] <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_s1    <= kind;
			chan_s1    <= channel;
			amount_s1  <= amount;
			chan_ok_s1 <= chan_ok;
			rd_vld_s1  <= valid_q[channel];
		end
		if (done) begin
			offset_q  <= res_offset;
			granted_q <= res_granted;
			clamped_q <= res_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			valid_q     <= '0;
			ring_size_q <= RING_SIZE_RST;
		end else begin
			if (req_fire) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (~rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				ring_size_q <= pwdata[CNT_W-1:0];
				valid_q     <= '0;
			end else if (done && chan_ok_s1 && is_cmt) begin
				valid_q[chan_s1] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[sv/mcrpm_checker.sv]
// Port-level checker for the multi-channel ring pointer manager, with its bind.
// Depends on mcrpm_pkg and the assertion macro header.
`default_nettype none

`include "multi_channel_ring_pointer_manager_unit_defines.svh"

module mcrpm_checker
	import mcrpm_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             req_valid,
	input wire logic             req_stall,
	input wire logic             rsp_valid,
	input wire logic             rsp_stall,
	input wire logic [PTR_W-1:0] offset,
	input wire logic [CNT_W-1:0] granted,
	input wire logic             clamped,
	input wire logic             pready
);

	`MCRPM_ASSERT_NEXT(a_one_item_in_flight, req_valid && !req_stall, req_stall, "item accepted while another is in flight")
	`MCRPM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(offset) && $stable(granted) && $stable(clamped), "stalled response changed")
	`MCRPM_ASSERT_IMP(a_granted_range, rsp_valid, granted <= CNT_W'(RING_DEPTH), "granted exceeds ring depth")
	`MCRPM_ASSERT_IMP(a_pready_high, 1'b1, pready, "pready dropped")

endmodule

bind multi_channel_ring_pointer_manager_unit mcrpm_checker u_mcrpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.offset    (offset),
	.granted   (granted),
	.clamped   (clamped),
	.pready    (pready)
);

`default_nettype wire

[bench/ring_op_checker.sv]
// Checker for the multi-channel ring pointer manager: watches the request, response and APB ports.
// Keeps its own per-channel pointers and fill counts; depends on mcrpm_pkg.
`timescale 1ns / 100ps

module ring_op_checker
	import mcrpm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire logic              req_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [CH_W-1:0]   channel,
	input  wire logic [AMT_W-1:0]  amount,
	input  wire logic              rsp_valid,
	input  wire logic              rsp_stall,
	input  wire logic [PTR_W-1:0]  offset,
	input  wire logic [CNT_W-1:0]  granted,
	input  wire logic              clamped,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic              pready,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output int                     errors,
	output int                     outstanding
);

	typedef struct packed {
		logic [PTR_W-1:0] offset;
		logic [CNT_W-1:0] granted;
		logic             clamped;
	} ring_grant_t;

	logic [CNT_W-1:0] ring_size;
	logic [PTR_W-1:0] rd_pos   [CHANNELS];
	logic [PTR_W-1:0] wr_pos   [CHANNELS];
	logic [CNT_W-1:0] fill_cnt [CHANNELS];
	ring_grant_t      grants_due [$];
	ring_grant_t      due, seen;

	initial begin
		errors = 0;
		outstanding = 0;
	end

	function automatic int unsigned umin(input int unsigned a, input int unsigned b);
		return (a < b) ? a : b;
	endfunction

	task automatic clear_rings();
		for (int i = 0; i < CHANNELS; i++) begin
			rd_pos[i] = '0;
			wr_pos[i] = '0;
			fill_cnt[i] = '0;
		end
	endtask

	function automatic ring_grant_t apply_ring_op(input logic [1:0] k, input logic [CH_W-1:0] c,
			input logic [AMT_W-1:0] a);
		int unsigned n, fill, room, rp, wp, amt, g, nxt;
		ring_grant_t r;
		r = '0;
		n = ring_size;
		if (n == 0)
			n = 1;
		else if (n > RING_DEPTH)
			n = RING_DEPTH;
		amt = a;
		if (c < CHANNELS) begin
			fill = fill_cnt[c];
			room = n - fill;
			rp = rd_pos[c];
			wp = wr_pos[c];
			case (k)
				KIND_RSV_RD: begin
					r.offset = PTR_W'(rp);
					g = umin(umin(amt, fill), n - rp);
				end
				KIND_CMT_RD: begin
					r.offset = PTR_W'(rp);
					g = umin(amt, fill);
					r.clamped = (amt > fill);
					nxt = rp + g;
					if (nxt >= n)
						nxt -= n;
					rd_pos[c] = PTR_W'(nxt);
					fill_cnt[c] = CNT_W'(fill - g);
				end
				KIND_RSV_WR: begin
					r.offset = PTR_W'(wp);
					g = umin(umin(amt, room), n - wp);
				end
				default: begin
					r.offset = PTR_W'(wp);
					g = umin(amt, room);
					r.clamped = (amt > room);
					nxt = wp + g;
					if (nxt >= n)
						nxt -= n;
					wr_pos[c] = PTR_W'(nxt);
					fill_cnt[c] = CNT_W'(fill + g);
				end
			endcase
			r.granted = CNT_W'(g);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size = RING_SIZE_RST;
			clear_rings();
			grants_due.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				seen = '{offset, granted, clamped};
				if (grants_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected result offset=%0d granted=%0d clamped=%0d",
							$realtime, offset, granted, clamped);
					errors++;
				end else begin
					due = grants_due.pop_front();
					if (due !== seen) begin
						if (errors < 10)
							$display({"%0t: result mismatch: expected offset=%0d granted=%0d ",
								"clamped=%0d, got offset=%0d granted=%0d clamped=%0d"},
								$realtime, due.offset, due.granted, due.clamped,
								seen.offset, seen.granted, seen.clamped);
						errors++;
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == {REG_RING_SIZE, 2'b00}) begin
				ring_size = pwdata[CNT_W-1:0];
				clear_rings();
			end
			if (req_valid && !req_stall)
				grants_due.push_back(apply_ring_op(kind, channel, amount));
		end
		outstanding = grants_due.size();
	end

endmodule

[bench/testbench.sv]
// Top of the ring pointer manager bench: clock, reset, request and APB stimulus, verdict.
// Depends on mcrpm_pkg, multi_channel_ring_pointer_manager_unit and ring_op_checker.
`timescale 1ns / 100ps

module testbench
	import mcrpm_pkg::*;
();

	localparam logic [APB_AW-1:0] RING_SIZE_ADDR = {REG_RING_SIZE, 2'b00};
	localparam logic [APB_AW-1:0] NO_REG_ADDR    = 3'd4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 131;

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic [1:0]        kind      = KIND_RSV_RD;
	logic [CH_W-1:0]   channel   = '0;
	logic [AMT_W-1:0]  amount    = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [PTR_W-1:0]  offset;
	logic [CNT_W-1:0]  granted;
	logic              clamped;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	int                errors;
	int                outstanding;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	bit hold_req      = 1'b0;
	int quiet_cycles  = 0;

	multi_channel_ring_pointer_manager_unit dut (.*);
	ring_op_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				rsp_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_op(input logic [1:0] k, input logic [CH_W-1:0] c,
			input logic [AMT_W-1:0] a);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		channel <= c;
		amount <= a;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		int unsigned phase_size [8];
		int unsigned n, sel, amt;
		logic [CH_W-1:0] ch;

		phase_size = '{1024, 2, 1, 0, 1023, 7, 2047, 0};
		phase_size[7] = $urandom_range(3, RING_DEPTH);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(KIND_RSV_RD, 0, 5);
		send_op(KIND_CMT_RD, 0, 1024);
		send_op(KIND_RSV_WR, 1, 2047);
		send_op(KIND_CMT_WR, 7, 1024);
		send_op(KIND_CMT_WR, 7, 1);
		send_op(KIND_RSV_WR, 7, 0);
		send_op(KIND_RSV_RD, 7, 2047);
		send_op(KIND_CMT_RD, 7, 1000);
		send_op(KIND_CMT_WR, 7, 1000);
		send_op(KIND_RSV_WR, 7, 100);
		send_op(KIND_RSV_RD, 7, 100);
		drain_results();
		reg_write(NO_REG_ADDR, 5);
		send_op(KIND_RSV_RD, 7, 100);
		drain_results();
		reg_write(RING_SIZE_ADDR, 0);
		send_op(KIND_CMT_WR, 2, 1);
		send_op(KIND_RSV_WR, 2, 1);
		send_op(KIND_CMT_RD, 2, 5);
		send_op(KIND_RSV_RD, 2, 1);
		drain_results();
		reg_write(RING_SIZE_ADDR, 10);
		send_op(KIND_CMT_WR, 3, 7);
		send_op(KIND_CMT_RD, 3, 7);
		send_op(KIND_RSV_WR, 3, 10);
		send_op(KIND_CMT_WR, 3, 10);
		send_op(KIND_RSV_RD, 3, 10);
		send_op(KIND_CMT_RD, 3, 4);

		for (int p = 0; p < 8; p++) begin
			drain_results();
			reg_write(RING_SIZE_ADDR, ($urandom() & ~32'h7FF) | phase_size[p]);
			n = phase_size[p] & 32'h7FF;
			if (n == 0)
				n = 1;
			else if (n > RING_DEPTH)
				n = RING_DEPTH;
			case (p % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 73; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 73; end
				default: begin send_idle_pct = 21; stall_pct = 21; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 60)
					drain_results();
				if (p == 4 && i == 20)
					hold_req = 1'b1;
				sel = $urandom_range(99);
				if (sel < 45)
					amt = $urandom_range(0, n);
				else if (sel < 70)
					amt = $urandom_range(0, 3);
				else if (sel < 82)
					amt = n + $urandom_range(0, 2) - 1;
				else if (sel < 90)
					amt = $urandom_range(0, 2047);
				else
					amt = RING_DEPTH;
				if ($urandom_range(99) < 70)
					ch = CH_W'($urandom_range(0, 2));
				else
					ch = CH_W'($urandom_range(0, CHANNELS - 1));
				send_op(2'($urandom_range(0, 3)), ch, AMT_W'(amt));
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[multi_channel_ring_pointer_manager_unit.f]
+incdir+sv
sv/mcrpm_pkg.sv
sv/multi_channel_ring_pointer_manager_unit.sv
sv/mcrpm_checker.sv
bench/ring_op_checker.sv
bench/testbench.sv
